// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shape ring vertex generator
// Clocked property checks that share one clock and reset form.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SRVG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srvg assertion failed");

// Check that a condition never holds outside reset
`define SRVG_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("srvg forbidden condition seen");

`endif

// File: src/srvg_pkg.sv
// ----------------------------------------------------------------------------
// srvg_pkg
// Types, constants and small tables for the shape ring vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package srvg_pkg;

    localparam int COORD_BITS       = 32;
    localparam int MAX_SEGMENTS_DEF = 63;

    // Shape codes
    localparam logic [1:0] SHAPE_RECT = 2'd0;
    localparam logic [1:0] SHAPE_DIAM = 2'd1;
    localparam logic [1:0] SHAPE_OVAL = 2'd2;

    // Register indexes
    localparam logic REG_SHAPE_KIND    = 1'b0;
    localparam logic REG_OVAL_SEGMENTS = 1'b1;

    localparam logic [1:0] SHAPE_RESET = SHAPE_RECT;
    localparam logic [5:0] SEG_RESET   = 6'd36;

    // Angles in 1/65536 degree
    localparam logic [24:0] FULL_TURN   = 25'd23592960;
    localparam logic [24:0] RIGHT_ANGLE = 25'd5898240;
    localparam int          CORDIC_LAST = 16;
    localparam logic signed [19:0] CORDIC_START = 20'sd39797;
    localparam logic signed [17:0] ONE_Q16      = 18'sd65536;

    // Sign codes of the corner tables
    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [30:0] full_width;
        logic        [30:0] full_height;
        logic signed [15:0] turn_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
        logic                         size_error;
    } out_item_t;

    // CORDIC arc per step, 1/65536 degree
    function automatic logic [22:0] arc_angle(input logic [4:0] step);
        logic [22:0] v;
        case (step)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117305;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

    // Corner sign for rectangle and diamond rings
    function automatic logic [1:0] corner_sign(input logic diamond, input logic y_axis,
                                               input logic [2:0] k);
        logic [1:0] v;
        v = SGN_ZERO;
        case ({diamond, y_axis})
            2'b00: case (k)
                3'd0, 3'd1, 3'd4: v = SGN_NEG;
                3'd2, 3'd3:       v = SGN_POS;
                default:          v = SGN_ZERO;
            endcase
            2'b01: case (k)
                3'd0, 3'd3, 3'd4: v = SGN_NEG;
                3'd1, 3'd2:       v = SGN_POS;
                default:          v = SGN_ZERO;
            endcase
            2'b10: case (k)
                3'd1:    v = SGN_NEG;
                3'd3:    v = SGN_POS;
                default: v = SGN_ZERO;
            endcase
            default: case (k)
                3'd0, 3'd4: v = SGN_NEG;
                3'd2:       v = SGN_POS;
                default:    v = SGN_ZERO;
            endcase
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: src/shape_ring_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// shape_ring_vertex_generator_core
// Emits the closed vertex ring of a rectangle, diamond or oval about a point.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid / in_stall / in_item carries one shape request.
//   Output channel out_valid / out_stall / out_item carries one vertex per
//   item; last_vertex marks the closing vertex. A zero width or height gives
//   one item with size_error and last_vertex set and zero coordinates.
//   Registers shape_kind (index 0) and oval_segments (index 1) are written
//   through cfg_we / cfg_index / cfg_data; the user must do so only while
//   the block is idle, which the block itself does not enforce.
//   One request is processed at a time; in_stall is high until the last
//   vertex has been handed to the output register.
//   The oval path runs the shared 17-step CORDIC per vertex and the
//   25-step restoring divider for the angle increment; the rotated offsets
//   take four passes through the single 33x18 multiplier.
//   A stalled output holds its item and the sequencer waits on it.
//   Reset returns to idle, drops any pending vertex and restores the
//   registers to rectangle and 36 segments.
`default_nettype none

module shape_ring_vertex_generator_core #(
    parameter int MAX_SEGMENTS = srvg_pkg::MAX_SEGMENTS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  srvg_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  wire                  out_stall,
    output srvg_pkg::out_item_t  out_item,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire  [5:0]           cfg_data
);
    import srvg_pkg::*;

`include "assert_macros.svh"

    localparam int OFS_W = 34;
    localparam int SUM_W = ((COORD_BITS > OFS_W) ? COORD_BITS : OFS_W) + 2;
    localparam logic [5:0] SEG_MAX = 6'(MAX_SEGMENTS);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_VTX   = 4'd2;
    localparam logic [3:0] S_CORD  = 4'd3;
    localparam logic [3:0] S_CDONE = 4'd4;
    localparam logic [3:0] S_MW    = 4'd5;
    localparam logic [3:0] S_MH    = 4'd6;
    localparam logic [3:0] S_OFS   = 4'd7;
    localparam logic [3:0] S_R0    = 4'd8;
    localparam logic [3:0] S_R1    = 4'd9;
    localparam logic [3:0] S_R2    = 4'd10;
    localparam logic [3:0] S_R3    = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_ROTL  = 4'd13;

    // Control state
    logic [3:0] state_reg, state_next;
    logic [1:0] shape_reg, shape_next;
    logic [5:0] segcfg_reg, segcfg_next;
    logic       out_valid_reg, out_valid_next;
    logic [4:0] step_reg, step_next;
    logic [5:0] k_reg, k_next;

    // Item payload
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [30:0]        w_reg, w_next, h_reg, h_next;
    logic               oval_reg, oval_next, diam_reg, diam_next;
    logic               rot_reg, rot_next, err_reg, err_next;
    logic [5:0]         seg_reg, seg_next;
    logic [24:0]        angm_reg, angm_next;

    // Oval angle stepping
    logic [6:0]  drem_reg, drem_next;
    logic [24:0] q0_reg, q0_next, t_reg, t_next;
    logic [5:0]  r0_reg, r0_next, trem_reg, trem_next;

    // CORDIC unit
    logic signed [19:0] x_reg, x_next, y_reg, y_next;
    logic signed [26:0] a_reg, a_next;
    logic               flip_reg, flip_next, forrot_reg, forrot_next;
    logic signed [17:0] rc_reg, rc_next, rs_reg, rs_next, tc_reg, tc_next, ts_reg, ts_next;

    // Offsets and accumulator
    logic signed [32:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic signed [51:0]    acc_reg, acc_next;
    logic signed [OFS_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    out_item_t             out_reg, out_next;

    // Shared multiplier and helpers
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] prod;
    logic signed [52:0] rsum;
    logic signed [50:0] prnd;
    logic signed [26:0] ang_ext, ang_a1;
    logic [24:0]        cl_ang;
    logic signed [26:0] cl_a;
    logic               cl_flip;
    logic signed [19:0] x_sh, y_sh, xf, yf;
    logic signed [17:0] xc, yc;
    logic [6:0]         div_sh, tsum;
    logic signed [33:0] hx, hy;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic [1:0]         sgn_x, sgn_y;
    logic               last_k, out_free;
    logic [5:0]         seg_in;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_k    = oval_reg ? (k_reg == seg_reg) : (k_reg == 6'd4);

    // Clamp the segment count
    assign seg_in = (segcfg_reg == 6'd0) ? 6'd1 :
                    ((segcfg_reg > SEG_MAX) ? SEG_MAX : segcfg_reg);

    // Reduce the rotation angle into one full turn
    assign ang_ext = 27'(signed'({in_item.turn_angle, 10'b0}));
    assign ang_a1  = (ang_ext < 0) ? ang_ext + 27'(FULL_TURN) : ang_ext;

    // Fold the CORDIC start angle into the right half plane
    assign cl_ang = (state_reg == S_ROTL) ? angm_reg : ((k_reg == seg_reg) ? 25'd0 : t_reg);
    always_comb
    begin
        cl_flip = 1'b0;
        cl_a    = signed'({2'b00, cl_ang});
        if (cl_ang > RIGHT_ANGLE && cl_ang < 25'(3 * RIGHT_ANGLE))
        begin
            cl_a    = signed'({2'b00, cl_ang}) - 27'(2 * RIGHT_ANGLE);
            cl_flip = 1'b1;
        end
        else if (cl_ang >= 25'(3 * RIGHT_ANGLE))
        begin
            cl_a = signed'({2'b00, cl_ang}) - 27'(FULL_TURN);
        end
    end

    assign x_sh = x_reg >>> step_reg;
    assign y_sh = y_reg >>> step_reg;
    assign xf   = flip_reg ? -x_reg : x_reg;
    assign yf   = flip_reg ? -y_reg : y_reg;
    assign xc   = (xf > 20'(ONE_Q16)) ? ONE_Q16 : ((xf < -20'(ONE_Q16)) ? -ONE_Q16 : 18'(xf));
    assign yc   = (yf > 20'(ONE_Q16)) ? ONE_Q16 : ((yf < -20'(ONE_Q16)) ? -ONE_Q16 : 18'(yf));

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MW:    begin mul_a = signed'({2'b00, w_reg}); mul_b = tc_reg; end
            S_MH:    begin mul_a = signed'({2'b00, h_reg}); mul_b = ts_reg; end
            S_R0:    begin mul_a = dx_reg; mul_b = rc_reg; end
            S_R1:    begin mul_a = dy_reg; mul_b = rs_reg; end
            S_R2:    begin mul_a = dy_reg; mul_b = rc_reg; end
            S_R3:    begin mul_a = dx_reg; mul_b = rs_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = 51'(mul_a) * 51'(mul_b);
    assign prnd = prod + 51'sd32768;
    assign rsum = ((state_reg == S_R3) ? 53'(acc_reg) - 53'(prod) : 53'(acc_reg) + 53'(prod))
                  + 53'sd65536;

    assign div_sh = {drem_reg[5:0], FULL_TURN[step_reg]};
    assign tsum   = 7'(trem_reg) + 7'(r0_reg);

    assign hx = (signed'({dx_reg[32], dx_reg}) + 34'sd1) >>> 1;
    assign hy = (signed'({dy_reg[32], dy_reg}) + 34'sd1) >>> 1;

    assign sgn_x = corner_sign(diam_reg, 1'b0, k_reg[2:0]);
    assign sgn_y = corner_sign(diam_reg, 1'b1, k_reg[2:0]);

    assign sum_x = SUM_W'(cx_reg) + SUM_W'(ox_reg);
    assign sum_y = SUM_W'(cy_reg) + SUM_W'(oy_reg);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;   shape_next = shape_reg;   segcfg_next = segcfg_reg;
        out_valid_next = out_valid_reg && out_stall;
        step_next = step_reg;     k_next = k_reg;
        cx_next = cx_reg; cy_next = cy_reg; w_next = w_reg; h_next = h_reg;
        oval_next = oval_reg; diam_next = diam_reg; rot_next = rot_reg; err_next = err_reg;
        seg_next = seg_reg; angm_next = angm_reg;
        drem_next = drem_reg; q0_next = q0_reg; t_next = t_reg;
        r0_next = r0_reg; trem_next = trem_reg;
        x_next = x_reg; y_next = y_reg; a_next = a_reg;
        flip_next = flip_reg; forrot_next = forrot_reg;
        rc_next = rc_reg; rs_next = rs_reg; tc_next = tc_reg; ts_next = ts_reg;
        dx_next = dx_reg; dy_next = dy_reg; acc_next = acc_reg;
        ox_next = ox_reg; oy_next = oy_reg; out_next = out_reg;

        // Take register writes
        if (cfg_we)
        begin
            if (cfg_index == REG_SHAPE_KIND)
                shape_next = cfg_data[1:0];
            else
                segcfg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cx_next   = in_item.center_x;
                    cy_next   = in_item.center_y;
                    w_next    = in_item.full_width;
                    h_next    = in_item.full_height;
                    oval_next = (shape_reg == SHAPE_OVAL);
                    diam_next = (shape_reg == SHAPE_DIAM);
                    rot_next  = (in_item.turn_angle != 16'sd0);
                    err_next  = (in_item.full_width == 31'd0) || (in_item.full_height == 31'd0);
                    seg_next  = seg_in;
                    angm_next = (ang_a1 < 0) ? 25'(ang_a1 + 27'(FULL_TURN)) :
                                ((ang_a1 >= 27'(FULL_TURN)) ? 25'(ang_a1 - 27'(FULL_TURN))
                                                             : 25'(ang_a1));
                    rc_next   = ONE_Q16;
                    rs_next   = '0;
                    k_next    = '0;
                    drem_next = '0;
                    step_next = 5'd24;
                    if ((in_item.full_width == 31'd0) || (in_item.full_height == 31'd0))
                        state_next = S_EMIT;
                    else if (shape_reg == SHAPE_OVAL)
                        state_next = S_DIV;
                    else if (in_item.turn_angle != 16'sd0)
                        state_next = S_ROTL;
                    else
                        state_next = S_VTX;
                end
            end
            S_DIV:
            begin
                // One quotient bit of the full turn over the segment count
                if (div_sh >= 7'(seg_reg))
                begin
                    drem_next = div_sh - 7'(seg_reg);
                    q0_next   = {q0_reg[23:0], 1'b1};
                end
                else
                begin
                    drem_next = div_sh;
                    q0_next   = {q0_reg[23:0], 1'b0};
                end
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    r0_next    = (div_sh >= 7'(seg_reg)) ? 6'(div_sh - 7'(seg_reg)) : div_sh[5:0];
                    t_next     = '0;
                    trem_next  = seg_reg >> 1;
                    state_next = rot_reg ? S_ROTL : S_VTX;
                end
            end
            S_ROTL:
            begin
                x_next = CORDIC_START; y_next = '0; a_next = cl_a;
                flip_next = cl_flip; forrot_next = 1'b1; step_next = '0;
                state_next = S_CORD;
            end
            S_VTX:
            begin
                if (oval_reg)
                begin
                    x_next = CORDIC_START; y_next = '0; a_next = cl_a;
                    flip_next = cl_flip; forrot_next = 1'b0; step_next = '0;
                    state_next = S_CORD;
                end
                else
                begin
                    dx_next = (sgn_x == SGN_POS) ? signed'({2'b00, w_reg}) :
                              ((sgn_x == SGN_NEG) ? -signed'({2'b00, w_reg}) : 33'sd0);
                    dy_next = (sgn_y == SGN_POS) ? signed'({2'b00, h_reg}) :
                              ((sgn_y == SGN_NEG) ? -signed'({2'b00, h_reg}) : 33'sd0);
                    state_next = S_OFS;
                end
            end
            S_CORD:
            begin
                // One micro-rotation
                if (a_reg >= 0)
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    a_next = a_reg - 27'(arc_angle(step_reg));
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    a_next = a_reg + 27'(arc_angle(step_reg));
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_LAST))
                    state_next = S_CDONE;
            end
            S_CDONE:
            begin
                if (forrot_reg)
                begin
                    rc_next = xc; rs_next = yc; state_next = S_VTX;
                end
                else
                begin
                    tc_next = xc; ts_next = yc; state_next = S_MW;
                end
            end
            S_MW:
            begin
                dx_next = prnd[48:16];
                state_next = S_MH;
            end
            S_MH:
            begin
                dy_next = prnd[48:16];
                state_next = S_OFS;
            end
            S_OFS:
            begin
                if (rot_reg)
                    state_next = S_R0;
                else
                begin
                    ox_next = hx; oy_next = hy; state_next = S_EMIT;
                end
            end
            S_R0:
            begin
                acc_next = 52'(prod); state_next = S_R1;
            end
            S_R1:
            begin
                ox_next = rsum[17 +: OFS_W]; state_next = S_R2;
            end
            S_R2:
            begin
                acc_next = 52'(prod); state_next = S_R3;
            end
            S_R3:
            begin
                oy_next = rsum[17 +: OFS_W]; state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        out_next.vertex_x    = '0;
                        out_next.vertex_y    = '0;
                        out_next.last_vertex = 1'b1;
                        out_next.size_error  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_next.vertex_x = (sum_x > SAT_HI) ? SAT_HI[COORD_BITS-1:0] :
                                            ((sum_x < SAT_LO) ? SAT_LO[COORD_BITS-1:0]
                                                              : sum_x[COORD_BITS-1:0]);
                        out_next.vertex_y = (sum_y > SAT_HI) ? SAT_HI[COORD_BITS-1:0] :
                                            ((sum_y < SAT_LO) ? SAT_LO[COORD_BITS-1:0]
                                                              : sum_y[COORD_BITS-1:0]);
                        out_next.last_vertex = last_k;
                        out_next.size_error  = 1'b0;
                        // Advance the oval angle by the full turn over N
                        k_next = k_reg + 6'd1;
                        if (tsum >= 7'(seg_reg))
                        begin
                            trem_next = 6'(tsum - 7'(seg_reg));
                            t_next    = t_reg + q0_reg + 25'd1;
                        end
                        else
                        begin
                            trem_next = tsum[5:0];
                            t_next    = t_reg + q0_reg;
                        end
                        state_next = last_k ? S_IDLE : S_VTX;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shape_reg     <= SHAPE_RESET;
            segcfg_reg    <= SEG_RESET;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            shape_reg     <= shape_next;
            segcfg_reg    <= segcfg_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next; cy_reg <= cy_next; w_reg <= w_next; h_reg <= h_next;
        oval_reg <= oval_next; diam_reg <= diam_next; rot_reg <= rot_next;
        err_reg <= err_next; seg_reg <= seg_next; angm_reg <= angm_next;
        drem_reg <= drem_next; q0_reg <= q0_next; t_reg <= t_next;
        r0_reg <= r0_next; trem_reg <= trem_next;
        x_reg <= x_next; y_reg <= y_next; a_reg <= a_next;
        flip_reg <= flip_next; forrot_reg <= forrot_next;
        rc_reg <= rc_next; rs_reg <= rs_next; tc_reg <= tc_next; ts_reg <= ts_next;
        dx_reg <= dx_next; dy_reg <= dy_next; acc_reg <= acc_next;
        ox_reg <= ox_next; oy_reg <= oy_next; out_reg <= out_next;
    end

    `SRVG_ASSERT(a_err_is_last, (out_valid && out_item.size_error) |-> out_item.last_vertex)
    `SRVG_NEVER(a_k_past_ring, (state_reg == S_EMIT) && !err_reg && oval_reg && (k_reg > seg_reg))
    `SRVG_NEVER(a_cordic_overrun, (state_reg == S_CORD) && (step_reg > 5'(CORDIC_LAST)))
    `SRVG_NEVER(a_emit_on_stalled_full, (state_reg == S_EMIT) && out_valid_reg && out_stall
                && (state_next != S_EMIT))

endmodule

`default_nettype wire
